// ----- sv/cmi_pkg.sv -----
// Shared types and fixed widths for the complex matrix inverse.
// No dependencies; imported by complex_matrix_inverse.
package cmi_pkg;

  localparam int DATA_W = 32;
  localparam int SIZE_W = 3;

  // One complex entry, both parts signed fixed point
  typedef struct packed {
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } cplx_t;

endpackage

// ----- sv/complex_matrix_inverse.sv -----
// Complex matrix inverse by Gauss-Jordan elimination, one shared datapath.
// Depends on cmi_pkg (entry type, widths).

// Elements enter one word a cycle, row-major, until the marked word; the
// block then stalls its input, builds [A | I] in an on-chip store of
// MAX_SIZE x 2*MAX_SIZE complex entries (two registered read ports, one
// write port) and runs elimination without row swaps. Each entry of the
// pivot row goes through a 31-step restoring divider, each eliminated
// entry through four shared 32x32 multipliers. Results then leave one word
// at a time, each held until taken. A zero pivot clears its row and raises
// singular on every result word of that inversion.
// The input is also stalled while a size write is offered.
// Values are signed Q(32-FRAC_BITS).FRAC_BITS; products round to nearest
// (ties up) and saturate, quotients truncate toward zero and saturate.
module complex_matrix_inverse #(
  parameter int MAX_SIZE  = 4,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [cmi_pkg::DATA_W-1:0]   elem_re_i,
  input  logic signed [cmi_pkg::DATA_W-1:0]   elem_im_i,
  input  logic                                last_elem_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [cmi_pkg::DATA_W-1:0]   out_re_o,
  output logic signed [cmi_pkg::DATA_W-1:0]   out_im_o,
  output logic                                singular_o,
  output logic                                last_out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cmi_pkg::SIZE_W-1:0]          cfg_matrix_size_i
);
  import cmi_pkg::*;

  localparam int AUG_COLS = 2 * MAX_SIZE;
  localparam int DEPTH    = MAX_SIZE * AUG_COLS;
  localparam int AW       = $clog2(DEPTH);
  localparam int RW       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int CW       = $clog2(AUG_COLS);
  localparam int NW       = $clog2(MAX_SIZE + 1);
  localparam int SW       = 66;               // exact multiply-subtract sum
  localparam int QW       = DATA_W - 1;       // quotient bits below the sign
  localparam int KSH      = QW - FRAC_BITS;   // integer quotient bits

  localparam logic signed [DATA_W-1:0] ONE  = DATA_W'(1) <<< FRAC_BITS;
  localparam logic signed [DATA_W-1:0] DMAX = (DATA_W'(1) <<< QW) - DATA_W'(1);
  localparam logic signed [DATA_W-1:0] DMIN = DATA_W'(1) <<< QW;
  localparam logic signed [SW-1:0]     SMAX = SW'(DMAX);
  localparam logic signed [SW-1:0]     SMIN = SW'(DMIN);
  localparam logic signed [SW-1:0]     HALF = SW'(1) <<< (FRAC_BITS - 1);

  typedef enum logic [4:0] {
    S_LOAD, S_FILL, S_IDENT,
    S_PIV_RD, S_PIV_OP, S_PIV_MUL, S_PIV_DEN,
    S_DIV_RD, S_DIV_OP, S_DIV_MUL, S_DIV_INIT, S_DIV_RUN, S_DIV_WR,
    S_EL_T, S_EL_TOP, S_EL_RD, S_EL_OP, S_EL_MUL, S_EL_WR,
    S_EM_RD, S_EM_CAP, S_EM_HOLD
  } state_e;

  function automatic logic [AW-1:0] addr_f(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(int'(r) * AUG_COLS + int'(c));
  endfunction

  // Round a sum with 2*FRAC_BITS fraction bits and saturate to a word
  function automatic logic signed [DATA_W-1:0] rnd_sat(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] v;
    v = (s + HALF) >>> FRAC_BITS;
    if (v > SMAX) return DMAX;
    if (v < SMIN) return DMIN;
    return DATA_W'(v);
  endfunction

  state_e state_q;
  logic [SIZE_W-1:0] size_q;
  logic [RW-1:0] ld_r_q, ld_c_q, p_q, er_q, ec_q;
  logic          ld_full_q, sing_q, out_valid_q, last_q;
  logic [CW-1:0] c_q;
  logic [4:0]    div_cnt_q;

  // Effective order, clamped to 1..MAX_SIZE
  logic [NW-1:0] n;
  logic [RW-1:0] n_m1;
  logic [CW-1:0] col_last;
  always_comb begin
    if (size_q == '0) n = NW'(1);
    else if (int'(size_q) > MAX_SIZE) n = NW'(MAX_SIZE);
    else n = NW'(size_q);
  end
  assign n_m1     = RW'(n - NW'(1));
  assign col_last = CW'({n, 1'b0} - (NW + 1)'(1));

  // Storage and shared datapath registers
  cplx_t mem [DEPTH];
  cplx_t rd_a_q, rd_b_q, wd, x_q, t_q, out_q;
  logic [AW-1:0] ra, rb, wa;
  logic          we;

  logic signed [DATA_W-1:0]   ma [4];
  logic signed [DATA_W-1:0]   mb [4];
  logic signed [2*DATA_W-1:0] pq [4];
  logic signed [DATA_W-1:0]   pr_q, pi_q;
  logic [63:0]                den_q;
  logic                       den_zero;

  logic [63:0] dv_r   [2];
  logic [QW-1:0] dv_d [2];
  logic [QW-1:0] dv_q [2];
  logic        dv_neg [2];
  logic        dv_sat [2];

  logic in_acc, cfg_acc, out_acc, em_last;
  assign in_acc   = in_valid_i && !in_stall_o;
  assign cfg_acc  = cfg_valid_i && (state_q == S_LOAD);
  assign out_acc  = out_valid_q && !out_stall_i;
  assign den_zero = (den_q == '0);
  assign em_last  = (er_q == n_m1) && (ec_q == n_m1);

  // Hold the input off while computing or emitting, or while a size write is offered
  assign in_stall_o  = (state_q != S_LOAD) || cfg_valid_i;
  assign cfg_ready_o = (state_q == S_LOAD);
  assign out_valid_o = out_valid_q;
  assign out_re_o    = out_q.re;
  assign out_im_o    = out_q.im;
  assign singular_o  = sing_q;
  assign last_out_o  = last_q;

  // Divider result lanes: zero on a zero pivot, else signed or saturated quotient
  logic signed [DATA_W-1:0] dres [2];
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (den_zero) dres[i] = '0;
      else if (dv_sat[i]) dres[i] = dv_neg[i] ? DMIN : DMAX;
      else if (dv_neg[i]) dres[i] = -$signed({1'b0, dv_q[i]});
      else dres[i] = $signed({1'b0, dv_q[i]});
    end
  end

  // Elimination result for the current entry
  logic signed [SW-1:0] s_re, s_im;
  assign s_re = (SW'(x_q.re) <<< FRAC_BITS) - SW'(pq[0]) + SW'(pq[1]);
  assign s_im = (SW'(x_q.im) <<< FRAC_BITS) - SW'(pq[2]) - SW'(pq[3]);

  // Memory addresses and write data by phase
  always_comb begin
    ra = '0;
    rb = '0;
    wa = addr_f(ld_r_q, CW'(ld_c_q));
    wd = '0;
    we = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        we    = in_acc && !ld_full_q;
        wd.re = elem_re_i;
        wd.im = elem_im_i;
      end
      S_FILL: we = !ld_full_q;
      S_IDENT: begin
        we    = 1'b1;
        wa    = addr_f(er_q, CW'(n) + CW'(ec_q));
        wd.re = (er_q == ec_q) ? ONE : '0;
      end
      S_PIV_RD: ra = addr_f(p_q, CW'(p_q));
      S_DIV_RD: ra = addr_f(p_q, c_q);
      S_DIV_WR: begin
        we    = 1'b1;
        wa    = addr_f(p_q, c_q);
        wd.re = dres[0];
        wd.im = dres[1];
      end
      S_EL_T: ra = addr_f(er_q, CW'(p_q));
      S_EL_RD: begin
        ra = addr_f(er_q, c_q);
        rb = addr_f(p_q, c_q);
      end
      S_EL_WR: begin
        we    = 1'b1;
        wa    = addr_f(er_q, c_q);
        wd.re = rnd_sat(s_re);
        wd.im = rnd_sat(s_im);
      end
      S_EM_RD: ra = addr_f(er_q, CW'(n) + CW'(ec_q));
      default: ;
    endcase
  end

  // Store: one write port, two registered read ports; the sequencer never
  // reads an entry in the cycle it is written
  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_a_q <= mem[ra];
    rd_b_q <= mem[rb];
  end

  // Four shared multipliers, registered products
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) pq[i] <= ma[i] * mb[i];
  end

  // Datapath registers: operands, pivot, divider lanes, output word
  always_ff @(posedge clk_i) begin
    logic signed [64:0] num [2];
    logic [63:0]        mag;
    logic [64:0]        rem;
    case (state_q)
      S_PIV_OP: begin
        pr_q  <= rd_a_q.re;
        pi_q  <= rd_a_q.im;
        ma[0] <= rd_a_q.re;  mb[0] <= rd_a_q.re;
        ma[1] <= rd_a_q.im;  mb[1] <= rd_a_q.im;
      end
      S_PIV_DEN: den_q <= 64'(pq[0]) + 64'(pq[1]);
      S_DIV_OP: begin
        ma[0] <= rd_a_q.re;  mb[0] <= pr_q;
        ma[1] <= rd_a_q.im;  mb[1] <= pi_q;
        ma[2] <= rd_a_q.im;  mb[2] <= pr_q;
        ma[3] <= rd_a_q.re;  mb[3] <= pi_q;
      end
      S_DIV_INIT: begin
        num[0] = 65'(pq[0]) + 65'(pq[1]);
        num[1] = 65'(pq[2]) - 65'(pq[3]);
        for (int i = 0; i < 2; i++) begin
          mag       = num[i][64] ? 64'(-num[i]) : 64'(num[i]);
          dv_neg[i] <= num[i][64];
          dv_sat[i] <= (mag >> KSH) >= den_q;
          dv_r[i]   <= mag >> KSH;
          dv_d[i]   <= QW'(mag << FRAC_BITS);
          dv_q[i]   <= '0;
        end
      end
      S_DIV_RUN: begin
        for (int i = 0; i < 2; i++) begin
          rem     = {dv_r[i], dv_d[i][QW-1]};
          dv_d[i] <= dv_d[i] << 1;
          if (rem >= {1'b0, den_q}) begin
            dv_r[i] <= 64'(rem - {1'b0, den_q});
            dv_q[i] <= {dv_q[i][QW-2:0], 1'b1};
          end else begin
            dv_r[i] <= 64'(rem);
            dv_q[i] <= {dv_q[i][QW-2:0], 1'b0};
          end
        end
      end
      S_EL_TOP: t_q <= rd_a_q;
      S_EL_OP: begin
        x_q   <= rd_a_q;
        ma[0] <= t_q.re;  mb[0] <= rd_b_q.re;
        ma[1] <= t_q.im;  mb[1] <= rd_b_q.im;
        ma[2] <= t_q.re;  mb[2] <= rd_b_q.im;
        ma[3] <= t_q.im;  mb[3] <= rd_b_q.re;
      end
      S_EM_CAP: out_q <= rd_a_q;
      default: ;
    endcase
  end

  // Sequencer: load, build [A | I], pivot, eliminate, emit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      size_q      <= SIZE_W'(4);
      ld_r_q      <= '0;
      ld_c_q      <= '0;
      ld_full_q   <= 1'b0;
      p_q         <= '0;
      er_q        <= '0;
      ec_q        <= '0;
      c_q         <= '0;
      div_cnt_q   <= '0;
      sing_q      <= 1'b0;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (cfg_acc) begin
            // a new size drops the partial frame
            size_q    <= cfg_matrix_size_i;
            ld_r_q    <= '0;
            ld_c_q    <= '0;
            ld_full_q <= 1'b0;
          end else if (in_acc) begin
            if (!ld_full_q) begin
              if (ld_c_q == n_m1) begin
                ld_c_q <= '0;
                if (ld_r_q == n_m1) ld_full_q <= 1'b1;
                else ld_r_q <= ld_r_q + RW'(1);
              end else begin
                ld_c_q <= ld_c_q + RW'(1);
              end
            end
            if (last_elem_i) state_q <= S_FILL;
          end
        end
        S_FILL: begin
          // zero the entries the frame did not deliver
          if (ld_full_q) begin
            ld_r_q    <= '0;
            ld_c_q    <= '0;
            ld_full_q <= 1'b0;
            er_q      <= '0;
            ec_q      <= '0;
            state_q   <= S_IDENT;
          end else if (ld_c_q == n_m1) begin
            ld_c_q <= '0;
            if (ld_r_q == n_m1) ld_full_q <= 1'b1;
            else ld_r_q <= ld_r_q + RW'(1);
          end else begin
            ld_c_q <= ld_c_q + RW'(1);
          end
        end
        S_IDENT: begin
          if (ec_q == n_m1) begin
            ec_q <= '0;
            if (er_q == n_m1) begin
              p_q     <= '0;
              sing_q  <= 1'b0;
              state_q <= S_PIV_RD;
            end else begin
              er_q <= er_q + RW'(1);
            end
          end else begin
            ec_q <= ec_q + RW'(1);
          end
        end
        S_PIV_RD:  state_q <= S_PIV_OP;
        S_PIV_OP:  state_q <= S_PIV_MUL;
        S_PIV_MUL: state_q <= S_PIV_DEN;
        S_PIV_DEN: begin
          if (64'(pq[0]) + 64'(pq[1]) == '0) sing_q <= 1'b1;
          c_q     <= '0;
          state_q <= S_DIV_RD;
        end
        S_DIV_RD:  state_q <= S_DIV_OP;
        S_DIV_OP:  state_q <= S_DIV_MUL;
        S_DIV_MUL: state_q <= S_DIV_INIT;
        S_DIV_INIT: begin
          div_cnt_q <= '0;
          state_q   <= den_zero ? S_DIV_WR : S_DIV_RUN;
        end
        S_DIV_RUN: begin
          div_cnt_q <= div_cnt_q + 5'd1;
          if (div_cnt_q == 5'(QW - 1)) state_q <= S_DIV_WR;
        end
        S_DIV_WR: begin
          if (c_q == col_last) begin
            er_q    <= '0;
            state_q <= S_EL_T;
          end else begin
            c_q     <= c_q + CW'(1);
            state_q <= S_DIV_RD;
          end
        end
        S_EL_T: begin
          // skip the pivot row itself
          if (er_q == p_q) begin
            if (er_q == n_m1) begin
              if (p_q == n_m1) begin
                er_q    <= '0;
                ec_q    <= '0;
                state_q <= S_EM_RD;
              end else begin
                p_q     <= p_q + RW'(1);
                state_q <= S_PIV_RD;
              end
            end else begin
              er_q <= er_q + RW'(1);
            end
          end else begin
            state_q <= S_EL_TOP;
          end
        end
        S_EL_TOP: begin
          c_q     <= CW'(p_q);
          state_q <= S_EL_RD;
        end
        S_EL_RD:  state_q <= S_EL_OP;
        S_EL_OP:  state_q <= S_EL_MUL;
        S_EL_MUL: state_q <= S_EL_WR;
        S_EL_WR: begin
          if (c_q == col_last) begin
            if (er_q == n_m1) begin
              if (p_q == n_m1) begin
                er_q    <= '0;
                ec_q    <= '0;
                state_q <= S_EM_RD;
              end else begin
                p_q     <= p_q + RW'(1);
                state_q <= S_PIV_RD;
              end
            end else begin
              er_q    <= er_q + RW'(1);
              state_q <= S_EL_T;
            end
          end else begin
            c_q     <= c_q + CW'(1);
            state_q <= S_EL_RD;
          end
        end
        S_EM_RD: state_q <= S_EM_CAP;
        S_EM_CAP: begin
          out_valid_q <= 1'b1;
          last_q      <= em_last;
          state_q     <= S_EM_HOLD;
        end
        S_EM_HOLD: begin
          // hold the word until taken, then advance
          if (out_acc) begin
            out_valid_q <= 1'b0;
            if (em_last) begin
              state_q <= S_LOAD;
            end else begin
              if (ec_q == n_m1) begin
                ec_q <= '0;
                er_q <= er_q + RW'(1);
              end else begin
                ec_q <= ec_q + RW'(1);
              end
              state_q <= S_EM_RD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

endmodule
